[rtl/xss_pkg.sv]
// Shared types and constants for the XY scan stepper.
package xss_pkg;

  localparam int OPCODE_W = 4;
  localparam int POS_W    = 32;
  localparam int AMOUNT_W = 9;
  localparam int CFG_W    = 31;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;
  localparam int ITER_W   = 5;
  localparam logic [ITER_W-1:0] ITER_LAST = '1;

  localparam logic [CFG_W-1:0] MAX_STEP_RST      = CFG_W'(167772);
  localparam logic [CFG_W-1:0] SETTLE_MARGIN_RST = CFG_W'(168);

  localparam logic [0:0] REG_MAX_STEP      = 1'b0;
  localparam logic [0:0] REG_SETTLE_MARGIN = 1'b1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK      = 4'd0,
    OP_SETPOINT  = 4'd1,
    OP_LOAD      = 4'd2,
    OP_CONFIGURE = 4'd3,
    OP_RUN       = 4'd4,
    OP_PAUSE     = 4'd5,
    OP_RESUME    = 4'd6,
    OP_STOP      = 4'd7,
    OP_ABORT     = 4'd8,
    OP_REWIND    = 4'd9
  } opcode_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_READY   = 2'd1,
    MODE_RUNNING = 2'd2,
    MODE_PAUSED  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_MODE  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_CAPTURE,
    DP_EXEC,
    DP_PREP,
    DP_SQUARE,
    DP_SUM,
    DP_COMPARE,
    DP_ROOT_STEP,
    DP_SCALE,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_STEP,
    DP_ADVANCE,
    DP_TAKE,
    DP_REPLY
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic moving;
    logic running;
    logic rewind_go;
    logic near;
    logic at_target;
    logic can_advance;
  } dp_stat_t;

endpackage

[rtl/xss_if.sv]
// Word channels of the scan stepper: item in, result out.
interface xss_item_if import xss_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OPCODE_W-1:0]        opcode;
  logic signed [POS_W-1:0]    pos_x;
  logic signed [POS_W-1:0]    pos_y;
  logic [AMOUNT_W-1:0]        amount;

  modport source (output valid, opcode, pos_x, pos_y, amount, input ready);
  modport sink   (input valid, opcode, pos_x, pos_y, amount, output ready);
endinterface

interface xss_result_if import xss_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic signed [POS_W-1:0]    target_x;
  logic signed [POS_W-1:0]    target_y;
  logic signed [POS_W-1:0]    actual_x;
  logic signed [POS_W-1:0]    actual_y;
  logic                       target_moved;
  logic                       actual_moved;
  logic                       mode_changed;
  logic                       scan_done;
  logic [1:0]                 error;
  logic [AMOUNT_W-1:0]        next_point;

  modport source (output valid, mode, target_x, target_y, actual_x, actual_y,
                  target_moved, actual_moved, mode_changed, scan_done, error,
                  next_point, input ready);
  modport sink   (input valid, mode, target_x, target_y, actual_x, actual_y,
                  target_moved, actual_moved, mode_changed, scan_done, error,
                  next_point, output ready);
endinterface

[rtl/xss_ctrl.sv]
// Sequencer for the scan stepper: decode, motion math steps, table fetch, reply.
module xss_ctrl import xss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_fire,
  input  logic     out_room,
  input  dp_stat_t stat,
  output logic     in_ready,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_SQUARE, S_SUM, S_COMPARE, S_ROOT, S_SCALE, S_DIV_INIT,
    S_DIVIDE, S_STEP, S_ADVANCE, S_FETCH, S_TAKE, S_REPLY
  } state_t;

  state_t              state, state_next;
  logic [ITER_W-1:0]   iter;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = DP_NONE;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.op     = DP_CAPTURE;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_tick) begin
          if (stat.moving) begin
            cmd.op     = DP_PREP;
            state_next = S_SQUARE;
          end else if (stat.running) begin
            state_next = S_ADVANCE;
          end else begin
            state_next = S_REPLY;
          end
        end else begin
          cmd.op     = DP_EXEC;
          state_next = stat.rewind_go ? S_FETCH : S_REPLY;
        end
      end
      S_SQUARE: begin
        cmd.op     = DP_SQUARE;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.op     = DP_SUM;
        state_next = S_COMPARE;
      end
      S_COMPARE: begin
        cmd.op = DP_COMPARE;
        if (!stat.near) state_next = S_ROOT;
        else state_next = stat.running ? S_ADVANCE : S_REPLY;
      end
      S_ROOT: begin
        cmd.op = DP_ROOT_STEP;
        if (iter == ITER_LAST) state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.op     = DP_SCALE;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op     = DP_DIV_INIT;
        state_next = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd.op = DP_DIV_STEP;
        if (iter == ITER_LAST) state_next = S_STEP;
      end
      S_STEP: begin
        cmd.op     = DP_STEP;
        state_next = stat.running ? S_ADVANCE : S_REPLY;
      end
      S_ADVANCE: begin
        cmd.op     = DP_ADVANCE;
        state_next = (stat.at_target && stat.can_advance) ? S_FETCH : S_REPLY;
      end
      S_FETCH: begin
        state_next = S_TAKE;
      end
      S_TAKE: begin
        cmd.op     = DP_TAKE;
        state_next = S_REPLY;
      end
      S_REPLY: begin
        if (out_room) begin
          cmd.op     = DP_REPLY;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      if (state == S_ROOT || state == S_DIVIDE) iter <= iter + 1'b1;
      else iter <= '0;
    end
  end

endmodule

[rtl/xss_dpath.sv]
// Scan stepper datapath: mode and coordinates, point table, root and divide units.
module xss_dpath import xss_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int COORD_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic [CFG_W-1:0]         max_step,
  input  logic [CFG_W-1:0]         settle_margin,
  input  logic [OPCODE_W-1:0]      item_opcode,
  input  logic signed [POS_W-1:0]  item_pos_x,
  input  logic signed [POS_W-1:0]  item_pos_y,
  input  logic [AMOUNT_W-1:0]      item_amount,
  output dp_stat_t                 stat,
  output logic [1:0]               mode_o,
  output logic signed [POS_W-1:0]  target_x,
  output logic signed [POS_W-1:0]  target_y,
  output logic signed [POS_W-1:0]  actual_x,
  output logic signed [POS_W-1:0]  actual_y,
  output logic                     target_moved,
  output logic                     actual_moved,
  output logic                     mode_changed,
  output logic                     scan_done,
  output logic [1:0]               error,
  output logic [AMOUNT_W-1:0]      next_point
);

  localparam int CW     = COORD_WIDTH;
  localparam int TW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int DW     = 33;
  localparam int MAG_W  = 31;
  localparam int SQ_W   = 64;
  localparam int PROD_W = 2 * MAG_W;
  localparam int QW     = 32;
  localparam logic [DW-1:0] DIFF_LIMIT = DW'(33'h07FFFFFFF);

  logic [OPCODE_W-1:0]      op;
  logic signed [CW-1:0]     px, py;
  logic [AMOUNT_W-1:0]      amt;

  mode_t                    mode;
  logic signed [CW-1:0]     set_x, set_y, rb_x, rb_y;
  logic [AMOUNT_W-1:0]      point_count, point_cursor;

  logic [MAG_W-1:0]         mag_x, mag_y;
  logic                     neg_x, neg_y;
  logic [SQ_W-1:0]          sq_x, sq_y, tt, s_sum;
  logic [SQ_W-1:0]          rn, rr, rbit;
  logic [PROD_W-1:0]        prod_x, prod_y;
  logic [QW-1:0]            rem_x, rem_y, quo_x, quo_y;

  logic [2*CW-1:0]          mem [TABLE_DEPTH];
  logic [TW-1:0]            raddr;
  logic [2*CW-1:0]          rdata;
  logic                     mem_we;

  logic                     at_target, can_advance, near;
  logic [SQ_W-1:0]          root_try;
  logic [QW-1:0]            ds;
  logic [AMOUNT_W-1:0]      rew_c, rew_cur;
  logic [QW-1:0]            tsum;

  function automatic logic [MAG_W:0] diff_mag(input logic signed [DW-1:0] d);
    logic [DW-1:0] m;
    m = d[DW-1] ? DW'(-d) : DW'(d);
    if (m > DIFF_LIMIT) m = DIFF_LIMIT;
    return {d[DW-1], m[MAG_W-1:0]};
  endfunction

  function automatic logic [QW:0] div_try(input logic [QW-1:0] rem, input logic msb,
                                          input logic [QW-1:0] dvs);
    logic [QW:0] t;
    t = {rem, msb};
    if (t >= {1'b0, dvs}) return {1'b1, QW'(t - {1'b0, dvs})};
    return {1'b0, t[QW-1:0]};
  endfunction

  function automatic logic signed [CW-1:0] apply_step(input logic signed [CW-1:0] p,
                                                      input logic neg,
                                                      input logic [QW-1:0] q);
    logic signed [DW-1:0] delta;
    delta = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    return CW'(DW'(p) + delta);
  endfunction

  assign at_target   = (set_x == rb_x) && (set_y == rb_y);
  assign can_advance = (point_cursor < point_count) && (32'(point_cursor) < TABLE_DEPTH);
  assign near        = !(s_sum > tt);
  assign root_try    = rr + rbit;
  assign ds          = rr[QW-1:0];
  assign tsum        = {1'b0, max_step} + {1'b0, settle_margin};

  always_comb begin
    if (amt < point_cursor) rew_c = point_cursor - amt - 1'b1;
    else rew_c = '0;
    if (32'(rew_c) >= TABLE_DEPTH) rew_c = AMOUNT_W'(TABLE_DEPTH - 1);
    rew_cur = rew_c + 1'b1;
  end

  assign stat.is_tick     = (op == OP_TICK);
  assign stat.moving      = (mode == MODE_IDLE || mode == MODE_RUNNING) && !at_target;
  assign stat.running     = (mode == MODE_RUNNING);
  assign stat.rewind_go   = (op == OP_REWIND) && (mode == MODE_RUNNING || mode == MODE_PAUSED)
                            && (amt != '0) && (point_count != '0);
  assign stat.near        = near;
  assign stat.at_target   = at_target;
  assign stat.can_advance = can_advance;

  assign mem_we = (cmd.op == DP_EXEC) && (op == OP_LOAD) && (mode == MODE_IDLE)
                  && (32'(amt) < TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (mem_we) mem[TW'(amt)] <= {px, py};
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      set_x        <= '0;
      set_y        <= '0;
      rb_x         <= '0;
      rb_y         <= '0;
      point_count  <= '0;
      point_cursor <= '0;
      target_moved <= 1'b0;
      actual_moved <= 1'b0;
      mode_changed <= 1'b0;
      scan_done    <= 1'b0;
      error        <= ERR_NONE;
    end else begin
      case (cmd.op)
        DP_CAPTURE: begin
          op           <= item_opcode;
          px           <= CW'(item_pos_x);
          py           <= CW'(item_pos_y);
          amt          <= item_amount;
          target_moved <= 1'b0;
          actual_moved <= 1'b0;
          mode_changed <= 1'b0;
          scan_done    <= 1'b0;
          error        <= ERR_NONE;
        end
        DP_EXEC: begin
          case (op)
            OP_SETPOINT: begin
              if (mode != MODE_IDLE) error <= ERR_MODE;
              else begin
                set_x        <= px;
                set_y        <= py;
                target_moved <= 1'b1;
              end
            end
            OP_LOAD: begin
              if (mode != MODE_IDLE) error <= ERR_MODE;
            end
            OP_CONFIGURE, OP_STOP, OP_ABORT: begin
              if ((op == OP_CONFIGURE && mode != MODE_IDLE) ||
                  (op == OP_STOP && mode == MODE_IDLE)) begin
                error <= ERR_MODE;
              end else begin
                if (op == OP_CONFIGURE) begin
                  mode        <= MODE_READY;
                  point_count <= (32'(amt) > TABLE_DEPTH) ? AMOUNT_W'(TABLE_DEPTH) : amt;
                end else if (op == OP_STOP) begin
                  mode <= MODE_READY;
                end else begin
                  mode        <= MODE_IDLE;
                  point_count <= '0;
                end
                mode_changed <= 1'b1;
                if (!at_target) begin
                  set_x        <= rb_x;
                  set_y        <= rb_y;
                  target_moved <= 1'b1;
                end
              end
            end
            OP_RUN: begin
              if (mode != MODE_READY) error <= ERR_MODE;
              else begin
                point_cursor <= '0;
                mode         <= MODE_RUNNING;
                mode_changed <= 1'b1;
              end
            end
            OP_PAUSE: begin
              if (mode != MODE_RUNNING) error <= ERR_MODE;
              else begin
                mode         <= MODE_PAUSED;
                mode_changed <= 1'b1;
              end
            end
            OP_RESUME: begin
              if (mode != MODE_PAUSED) error <= ERR_MODE;
              else begin
                mode         <= MODE_RUNNING;
                mode_changed <= 1'b1;
              end
            end
            OP_REWIND: begin
              if (mode != MODE_RUNNING && mode != MODE_PAUSED) error <= ERR_MODE;
              else if (amt != '0) begin
                if (point_count == '0) error <= ERR_EMPTY;
                else begin
                  raddr        <= TW'(rew_c);
                  point_cursor <= rew_cur;
                end
              end
            end
            default: ;
          endcase
        end
        DP_PREP: begin
          {neg_x, mag_x} <= diff_mag(DW'(set_x) - DW'(rb_x));
          {neg_y, mag_y} <= diff_mag(DW'(set_y) - DW'(rb_y));
        end
        DP_SQUARE: begin
          sq_x <= SQ_W'(mag_x * mag_x);
          sq_y <= SQ_W'(mag_y * mag_y);
          tt   <= SQ_W'(tsum * tsum);
        end
        DP_SUM: begin
          s_sum <= sq_x + sq_y;
        end
        DP_COMPARE: begin
          if (near) begin
            rb_x         <= set_x;
            rb_y         <= set_y;
            actual_moved <= 1'b1;
          end else begin
            rn   <= s_sum;
            rr   <= '0;
            rbit <= SQ_W'(1) << (SQ_W - 2);
          end
        end
        DP_ROOT_STEP: begin
          if (rn >= root_try) begin
            rn <= rn - root_try;
            rr <= (rr >> 1) + rbit;
          end else begin
            rr <= rr >> 1;
          end
          rbit <= rbit >> 2;
        end
        DP_SCALE: begin
          prod_x <= PROD_W'(mag_x * max_step);
          prod_y <= PROD_W'(mag_y * max_step);
        end
        DP_DIV_INIT: begin
          rem_x <= QW'(prod_x[PROD_W-1:QW]);
          rem_y <= QW'(prod_y[PROD_W-1:QW]);
          quo_x <= prod_x[QW-1:0];
          quo_y <= prod_y[QW-1:0];
        end
        DP_DIV_STEP: begin
          {quo_x[0], rem_x} <= div_try(rem_x, quo_x[QW-1], ds);
          {quo_y[0], rem_y} <= div_try(rem_y, quo_y[QW-1], ds);
          quo_x[QW-1:1]     <= quo_x[QW-2:0];
          quo_y[QW-1:1]     <= quo_y[QW-2:0];
        end
        DP_STEP: begin
          rb_x         <= apply_step(rb_x, neg_x, quo_x);
          rb_y         <= apply_step(rb_y, neg_y, quo_y);
          actual_moved <= 1'b1;
        end
        DP_ADVANCE: begin
          if (at_target) begin
            if (can_advance) begin
              raddr        <= TW'(point_cursor);
              point_cursor <= point_cursor + 1'b1;
            end else begin
              scan_done    <= 1'b1;
              mode         <= MODE_READY;
              mode_changed <= 1'b1;
            end
          end
        end
        DP_TAKE: begin
          set_x        <= rdata[2*CW-1:CW];
          set_y        <= rdata[CW-1:0];
          target_moved <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign mode_o     = mode;
  assign target_x   = POS_W'(set_x);
  assign target_y   = POS_W'(set_y);
  assign actual_x   = POS_W'(rb_x);
  assign actual_y   = POS_W'(rb_y);
  assign next_point = point_cursor;

`ifndef SYNTH
  a_cursor_in_count: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_RUNNING || mode == MODE_PAUSED) |-> point_cursor <= point_count)
    else $error("cursor past point count while scanning");
  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_SCALE) |-> ds != '0)
    else $error("zero root before divide");
  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DP_STEP) |-> (quo_x <= QW'(mag_x)) && (quo_y <= QW'(mag_y)))
    else $error("step larger than remaining distance");
`endif

endmodule

[rtl/xy_scan_stepper.sv]
// Top level of the XY scan stepper: APB registers, channels, result register.
//
//   channel   dir  protocol        word
//   item      in   valid/ready     opcode, pos_x, pos_y, amount
//   result    out  valid/ready     mode, setpoints, readbacks, flags, error, next_point
//   apb       in   psel/penable    max_step (0x0), settle_margin (0x4)
//
// A tick that steps runs the 32-step square root and the 32-step divide on the
// shared sequencer. One item is in work at a time; a finished word waits in the
// result register while the next item is taken. rst is synchronous; the point
// table is not cleared.
module xy_scan_stepper import xss_pkg::*; #(
  parameter int TABLE_DEPTH = 256,
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  xss_item_if.sink             item,
  xss_result_if.source         result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  logic [CFG_W-1:0]        max_step, settle_margin;
  dp_cmd_t                 cmd;
  dp_stat_t                stat;
  logic                    in_fire, out_room;

  logic [1:0]              d_mode, d_error;
  logic signed [POS_W-1:0] d_tx, d_ty, d_ax, d_ay;
  logic                    d_tm, d_am, d_mc, d_done;
  logic [AMOUNT_W-1:0]     d_next;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_step      <= MAX_STEP_RST;
      settle_margin <= SETTLE_MARGIN_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_MAX_STEP) max_step <= pwdata[CFG_W-1:0];
      else settle_margin <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_MAX_STEP) prdata = {1'b0, max_step};
    else prdata = {1'b0, settle_margin};
  end

  assign in_fire  = item.valid && item.ready;
  assign out_room = !result.valid || result.ready;

  xss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .out_room (out_room),
    .stat     (stat),
    .in_ready (item.ready),
    .cmd      (cmd)
  );

  xss_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .max_step      (max_step),
    .settle_margin (settle_margin),
    .item_opcode   (item.opcode),
    .item_pos_x    (item.pos_x),
    .item_pos_y    (item.pos_y),
    .item_amount   (item.amount),
    .stat          (stat),
    .mode_o        (d_mode),
    .target_x      (d_tx),
    .target_y      (d_ty),
    .actual_x      (d_ax),
    .actual_y      (d_ay),
    .target_moved  (d_tm),
    .actual_moved  (d_am),
    .mode_changed  (d_mc),
    .scan_done     (d_done),
    .error         (d_error),
    .next_point    (d_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (cmd.op == DP_REPLY) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_REPLY) begin
      result.mode         <= d_mode;
      result.target_x     <= d_tx;
      result.target_y     <= d_ty;
      result.actual_x     <= d_ax;
      result.actual_y     <= d_ay;
      result.target_moved <= d_tm;
      result.actual_moved <= d_am;
      result.mode_changed <= d_mc;
      result.scan_done    <= d_done;
      result.error        <= d_error;
      result.next_point   <= d_next;
    end
  end

endmodule

[verif/tb_top.sv]
// Testbench for the XY scan stepper: predicted results checked word by word.
module tb_top;
  import xss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;
  localparam longint DIFF_MAX = 64'sd2147483647;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] target_x;
    logic [31:0] target_y;
    logic [31:0] actual_x;
    logic [31:0] actual_y;
    logic        target_moved;
    logic        actual_moved;
    logic        mode_changed;
    logic        scan_done;
    logic [1:0]  error;
    logic [8:0]  next_point;
  } scan_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  xss_item_if   item ();
  xss_result_if result ();

  xy_scan_stepper DUT (
    .clk(clk), .rst(rst), .item(item), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // stepper state as predicted
  mode_t        st_mode;
  longint       st_target [2];
  longint       st_actual [2];
  longint       st_table [DEPTH][2];
  int unsigned  st_count;
  int unsigned  st_cursor;
  bit [63:0]    st_max_step;
  bit [63:0]    st_margin;

  scan_word_t   pending_words [$];
  int           mismatches = 0;
  int           words_sent = 0;
  int           long_hold = 0;
  int           coord_shift = 0;
  bit           send_quiet = 0;
  bit           recv_quiet = 0;

  function automatic bit [63:0] root_floor(bit [63:0] n);
    bit [63:0] r = 0;
    bit [63:0] b = 64'h4000_0000_0000_0000;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint axis_step(longint d, bit [63:0] ms, bit [63:0] ds);
    bit [63:0] mag;
    bit [63:0] q;
    mag = d < 0 ? 64'(-d) : 64'(d);
    q = mag * ms / ds;
    return d < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp_diff(longint d);
    if (d > DIFF_MAX) return DIFF_MAX;
    if (d < -DIFF_MAX) return -DIFF_MAX;
    return d;
  endfunction

  function automatic bit on_target();
    return st_target[0] == st_actual[0] && st_target[1] == st_actual[1];
  endfunction

  function automatic void hold_position();
    st_target[0] = st_actual[0];
    st_target[1] = st_actual[1];
  endfunction

  function automatic scan_word_t next_scan_word(logic [3:0] op, logic signed [31:0] px,
                                                logic signed [31:0] py, logic [8:0] amt);
    scan_word_t w;
    longint dx, dy;
    bit [63:0] s, t, ds;
    w = '0;
    case (op)
      OP_TICK: begin
        if (st_mode == MODE_IDLE || st_mode == MODE_RUNNING) begin
          if (!on_target()) begin
            dx = clamp_diff(st_target[0] - st_actual[0]);
            dy = clamp_diff(st_target[1] - st_actual[1]);
            s = 64'(dx * dx) + 64'(dy * dy);
            t = st_max_step + st_margin;
            if (s > t * t) begin
              ds = root_floor(s);
              st_actual[0] += axis_step(dx, st_max_step, ds);
              st_actual[1] += axis_step(dy, st_max_step, ds);
            end else begin
              st_actual[0] = st_target[0];
              st_actual[1] = st_target[1];
            end
            w.actual_moved = 1'b1;
          end
        end
        if (st_mode == MODE_RUNNING && on_target()) begin
          if (st_cursor < st_count && st_cursor < DEPTH) begin
            st_target[0] = st_table[st_cursor][0];
            st_target[1] = st_table[st_cursor][1];
            st_cursor++;
            w.target_moved = 1'b1;
          end else begin
            w.scan_done = 1'b1;
            st_mode = MODE_READY;
            w.mode_changed = 1'b1;
          end
        end
      end
      OP_SETPOINT: begin
        if (st_mode != MODE_IDLE) w.error = ERR_MODE;
        else begin
          st_target[0] = px;
          st_target[1] = py;
          w.target_moved = 1'b1;
        end
      end
      OP_LOAD: begin
        if (st_mode != MODE_IDLE) w.error = ERR_MODE;
        else if (amt < DEPTH) begin
          st_table[amt][0] = px;
          st_table[amt][1] = py;
        end
      end
      OP_CONFIGURE, OP_STOP, OP_ABORT: begin
        if (op == OP_CONFIGURE && st_mode != MODE_IDLE) w.error = ERR_MODE;
        else if (op == OP_STOP && st_mode == MODE_IDLE) w.error = ERR_MODE;
        else begin
          if (op == OP_CONFIGURE) begin
            st_mode = MODE_READY;
            st_count = amt > DEPTH ? DEPTH : amt;
          end else if (op == OP_STOP) begin
            st_mode = MODE_READY;
          end else begin
            st_mode = MODE_IDLE;
            st_count = 0;
          end
          w.mode_changed = 1'b1;
          if (!on_target()) begin
            hold_position();
            w.target_moved = 1'b1;
          end
        end
      end
      OP_RUN: begin
        if (st_mode != MODE_READY) w.error = ERR_MODE;
        else begin
          st_cursor = 0;
          st_mode = MODE_RUNNING;
          w.mode_changed = 1'b1;
        end
      end
      OP_PAUSE: begin
        if (st_mode != MODE_RUNNING) w.error = ERR_MODE;
        else begin
          st_mode = MODE_PAUSED;
          w.mode_changed = 1'b1;
        end
      end
      OP_RESUME: begin
        if (st_mode != MODE_PAUSED) w.error = ERR_MODE;
        else begin
          st_mode = MODE_RUNNING;
          w.mode_changed = 1'b1;
        end
      end
      OP_REWIND: begin
        if (st_mode != MODE_RUNNING && st_mode != MODE_PAUSED) w.error = ERR_MODE;
        else if (amt != 0) begin
          if (st_count == 0) w.error = ERR_EMPTY;
          else begin
            if (amt < st_cursor) st_cursor -= amt + 1;
            else st_cursor = 0;
            if (st_cursor >= DEPTH) st_cursor = DEPTH - 1;
            st_target[0] = st_table[st_cursor][0];
            st_target[1] = st_table[st_cursor][1];
            st_cursor++;
            w.target_moved = 1'b1;
          end
        end
      end
      default: ;
    endcase
    w.mode       = st_mode;
    w.target_x   = st_target[0][31:0];
    w.target_y   = st_target[1][31:0];
    w.actual_x   = st_actual[0][31:0];
    w.actual_y   = st_actual[1][31:0];
    w.next_point = st_cursor[8:0];
    return w;
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 9) == 0) return $signed($urandom);
    return $signed($urandom) >>> coord_shift;
  endfunction

  task automatic send_word(logic [3:0] op, logic signed [31:0] px, logic signed [31:0] py,
                           logic [8:0] amt);
    int gap;
    if ($urandom_range(0, 31) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.valid  <= 1'b1;
    item.opcode <= op;
    item.pos_x  <= px;
    item.pos_y  <= py;
    item.amount <= amt;
    do @(posedge clk); while (!item.ready);
    pending_words.insert(pending_words.size(), next_scan_word(op, px, py, amt));
    words_sent++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [CFG_W-1:0] v);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(idx) << 2; pwdata <= PDATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[CFG_W-1:0] !== v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d readback: expected %h, got %h", idx, v, prdata[CFG_W-1:0]);
    end
    psel <= 1'b0; penable <= 1'b0;
    if (idx == REG_MAX_STEP) st_max_step = 64'(v);
    else st_margin = 64'(v);
  endtask

  task automatic set_step(logic [CFG_W-1:0] step, logic [CFG_W-1:0] margin);
    item.valid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (100) @(posedge clk);
    write_reg(REG_MAX_STEP, step);
    write_reg(REG_SETTLE_MARGIN, margin);
  endtask

  // receiver: random stalls, long hold-off on request
  initial begin
    int gap;
    scan_word_t got, want;
    result.ready = 1'b0;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 31) == 0) recv_quiet = !recv_quiet;
      gap = recv_quiet ? 0 : $urandom_range(0, 14);
      if (long_hold > 0) begin
        gap = long_hold;
        long_hold = 0;
      end
      if (gap > 0) begin
        result.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result.ready <= 1'b1;
      do @(posedge clk); while (!result.valid);
      got = {result.mode, result.target_x, result.target_y, result.actual_x,
             result.actual_y, result.target_moved, result.actual_moved,
             result.mode_changed, result.scan_done, result.error, result.next_point};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %h", got);
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word mismatch\n  exp mode %0d tgt %h,%h act %h,%h flags %b%b%b%b ",
                      "err %0d next %0d\n  got mode %0d tgt %h,%h act %h,%h flags %b%b%b%b ",
                      "err %0d next %0d"},
                     want.mode, want.target_x, want.target_y, want.actual_x, want.actual_y,
                     want.target_moved, want.actual_moved, want.mode_changed,
                     want.scan_done, want.error, want.next_point,
                     got.mode, got.target_x, got.target_y, got.actual_x, got.actual_y,
                     got.target_moved, got.actual_moved, got.mode_changed,
                     got.scan_done, got.error, got.next_point);
        end
      end
    end
  end

  task automatic test_table_fill();
    for (int i = 0; i < DEPTH; i++)
      send_word(OP_LOAD, $signed($urandom), $signed($urandom), 9'(i));
  endtask

  task automatic test_directed();
    send_word(OP_TICK, 0, 0, 0);
    send_word(OP_SETPOINT, 32'sh7fffffff, 32'sh80000000, 0);
    send_word(OP_TICK, 0, 0, 0);
    send_word(OP_RUN, 0, 0, 0);
    send_word(OP_PAUSE, 0, 0, 0);
    send_word(OP_RESUME, 0, 0, 0);
    send_word(OP_STOP, 0, 0, 0);
    send_word(OP_REWIND, 0, 0, 1);
    send_word(OP_LOAD, 32'sh80000000, 32'sh7fffffff, 256);
    send_word(OP_LOAD, -1, -1, 511);
    send_word(4'd10, -1, -1, 511);
    send_word(4'd15, 0, 0, 0);
    send_word(OP_CONFIGURE, 0, 0, 511);
    send_word(OP_SETPOINT, 5, 5, 0);
    send_word(OP_RUN, 0, 0, 0);
    send_word(OP_PAUSE, 0, 0, 0);
    send_word(OP_REWIND, 0, 0, 0);
    send_word(OP_REWIND, 0, 0, 300);
    send_word(OP_RESUME, 0, 0, 0);
    send_word(OP_STOP, 0, 0, 0);
    send_word(OP_ABORT, 0, 0, 0);
    send_word(OP_CONFIGURE, 0, 0, 0);
    send_word(OP_RUN, 0, 0, 0);
    send_word(OP_REWIND, 0, 0, 1);
    send_word(OP_TICK, 0, 0, 0);
    send_word(OP_ABORT, 0, 0, 0);
  endtask

  task automatic scan_sequence();
    int r;
    send_word(OP_ABORT, 0, 0, 0);
    send_word(OP_SETPOINT, rand_coord(), rand_coord(), 0);
    repeat ($urandom_range(1, 6))
      send_word(OP_LOAD, rand_coord(), rand_coord(),
                9'($urandom_range(0, 19) == 0 ? $urandom_range(0, 511)
                                              : $urandom_range(0, 255)));
    send_word(OP_CONFIGURE, 0, 0,
              9'($urandom_range(0, 19) == 0 ? $urandom_range(0, 511) : $urandom_range(1, 8)));
    send_word(OP_RUN, 0, 0, 0);
    repeat ($urandom_range(6, 20)) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_word(OP_TICK, $urandom, $urandom, 9'($urandom));
      else if (r < 76) send_word(OP_PAUSE, 0, 0, 0);
      else if (r < 82) send_word(OP_RESUME, 0, 0, 0);
      else if (r < 90)
        send_word(OP_REWIND, 0, 0,
                  9'($urandom_range(0, 4) == 0 ? $urandom_range(0, 511)
                                               : $urandom_range(0, 6)));
      else if (r < 94) send_word(OP_STOP, 0, 0, 0);
      else if (r < 97) send_word(OP_RUN, 0, 0, 0);
      else send_word(OP_ABORT, 0, 0, 0);
    end
  endtask

  task automatic test_scan_phase(logic [CFG_W-1:0] step, logic [CFG_W-1:0] margin,
                                 int shift, int count);
    int stop_at;
    set_step(step, margin);
    coord_shift = shift;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0)
        send_word(4'($urandom_range(0, 15)), $urandom, $urandom, 9'($urandom));
      else
        scan_sequence();
    end
  endtask

  task automatic test_backpressure();
    long_hold = 400;
    send_quiet = 1;
    repeat (30) send_word(4'($urandom_range(0, 9)), rand_coord(), rand_coord(),
                          9'($urandom_range(0, 8)));
    send_quiet = 0;
  endtask

  initial begin
    item.valid = 1'b0;
    item.opcode = '0;
    item.pos_x = '0;
    item.pos_y = '0;
    item.amount = '0;
    st_mode = MODE_IDLE;
    st_target = '{0, 0};
    st_actual = '{0, 0};
    st_count = 0;
    st_cursor = 0;
    st_max_step = 64'(MAX_STEP_RST);
    st_margin = 64'(SETTLE_MARGIN_RST);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_fill();
    test_directed();
    test_scan_phase(31'd167772, 31'd168, 12, 260);
    test_scan_phase(31'h7fffffff, 31'd0, 0, 260);
    test_scan_phase(31'd1, 31'h7fffffff, 0, 200);
    test_backpressure();
    test_scan_phase(CFG_W'($urandom_range(1, 1 << 24)), CFG_W'($urandom_range(0, 1 << 20)),
                    $urandom_range(4, 14), 300);
    item.valid <= 1'b0;
    wait (pending_words.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #10ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

[sim.f]
rtl/xss_pkg.sv
rtl/xss_if.sv
rtl/xss_ctrl.sv
rtl/xss_dpath.sv
rtl/xy_scan_stepper.sv
verif/tb_top.sv
